// ----- sv/tce_pkg.sv -----
// package for the ttl cache with oldest-entry eviction
// item kind codes, register indexes, field widths and the compare result type
// no dependencies
package tce_pkg;

  localparam int KEY_W   = 64;
  localparam int STAMP_W = 32;
  localparam int TTL_W   = 31;
  localparam int LIM_W   = 5;
  localparam int RESP_W  = 32;
  localparam int CNT_W   = 5;
  localparam int KIND_W  = 3;
  localparam int CIDX_W  = 4;
  localparam int CDAT_W  = 32;

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PURGE = 3'd4;

  localparam logic [CIDX_W-1:0] REG_TTL = 4'd0;
  localparam logic [CIDX_W-1:0] REG_MAX = 4'd1;

  localparam logic [TTL_W-1:0] TTL_RESET = 31'd3600;
  localparam logic [LIM_W-1:0] MAX_RESET = 5'd16;

  // what the shared compare unit reports for one slot
  typedef struct packed {
    logic key_eq;
    logic expired;
    logic older;
  } cmp_t;

endpackage

// ----- sv/ttl_cache_oldest_evict_unit.sv -----
// Fully associative cache of DEPTH key hashes with ttl expiry and oldest-first eviction.
// One item is worked at a time; the entry store is read one slot per cycle into a single
// shared age/compare unit, so the slot scan sets the timing. A tick, a clear or an unused
// kind finishes without a scan; a get or a purge scans every slot once. A put scans
// every slot once, scans again for each entry evicted, and when the table was full on
// arrival then searches the slots for a free one to place the new entry.
// The input is stalled while an item is in work; a result waits in the output register
// and the next item may be taken meanwhile. Configuration writes are always taken.
// depends on tce_pkg, tce_store, tce_age_unit
module ttl_cache_oldest_evict_unit #(
  parameter int DEPTH     = 16,
  parameter int TAG_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tce_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tce_pkg::CDAT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tce_pkg::KIND_W-1:0]   kind,
  input  logic [tce_pkg::KEY_W-1:0]    key_hash,
  input  logic [tce_pkg::RESP_W-1:0]   response_tag,
  input  logic                         error_flag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic [tce_pkg::RESP_W-1:0]   hit_response,
  output logic                         hit_is_error,
  output logic [tce_pkg::CNT_W-1:0]    entry_count,
  output logic [tce_pkg::CNT_W-1:0]    error_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(DEPTH + 2);
  localparam int LW = (CW > tce_pkg::LIM_W) ? CW : tce_pkg::LIM_W;
  localparam int STW = tce_pkg::STAMP_W;
  localparam int W  = tce_pkg::KEY_W + TAG_WIDTH + 1 + STW;
  localparam logic [IW-1:0] LAST   = IW'(DEPTH - 1);
  localparam logic [SW-1:0] SCAN_N = SW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_EVCUT = 3'd3;
  localparam logic [2:0] S_EVCHK = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]                   state;
  logic [SW-1:0]                idx;
  logic                         p_vld;
  logic [IW-1:0]                p_idx;
  logic [DEPTH-1:0]             valid;
  logic [CW-1:0]                ent_cnt;
  logic [CW-1:0]                err_cnt;
  logic                         stg_valid;
  logic [STW-1:0]               time_now;
  logic [tce_pkg::TTL_W-1:0]    ttl;
  logic [tce_pkg::LIM_W-1:0]    max_ent;
  logic                         ev_scan;
  logic                         found;
  logic                         fill_found;
  logic                         best_found;

  logic [tce_pkg::KIND_W-1:0]   it_kind;
  logic [tce_pkg::KEY_W-1:0]    it_key;
  logic [TAG_WIDTH-1:0]         it_tag;
  logic                         it_err;
  logic                         hit_r;
  logic [TAG_WIDTH-1:0]         hit_resp;
  logic                         hit_err;
  logic [IW-1:0]                fill_idx;
  logic [IW-1:0]                best_idx;
  logic [STW-1:0]               best_age;
  logic                         best_err;

  logic [W-1:0]                 rd;
  logic [tce_pkg::KEY_W-1:0]    rd_key;
  logic [TAG_WIDTH-1:0]         rd_tag;
  logic                         rd_err;
  logic [STW-1:0]               rd_stamp;
  logic [STW-1:0]               age;
  tce_pkg::cmp_t                cmp;

  logic                         we;
  logic [IW-1:0]                waddr;
  logic [W-1:0]                 wdata;
  logic [IW-1:0]                vidx;
  logic                         v;
  logic                         proc;
  logic                         m_get;
  logic                         m_put;
  logic                         m_purge;
  logic                         get_take;
  logic                         hit_take;
  logic                         kill;
  logic                         fill_take;
  logic                         best_take;
  logic                         scan_end;
  logic [CW-1:0]                total;
  logic [LW-1:0]                limit;
  logic                         over;
  logic                         out_load;
  logic                         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);

  assign rd_key   = rd[W-1 -: tce_pkg::KEY_W];
  assign rd_tag   = rd[STW+1 +: TAG_WIDTH];
  assign rd_err   = rd[STW];
  assign rd_stamp = rd[STW-1:0];

  tce_store #(
    .DEPTH (DEPTH),
    .W     (W),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[IW-1:0]),
    .rdata (rd)
  );

  tce_age_unit u_age (
    .time_now (time_now),
    .stamp    (rd_stamp),
    .best_age (best_age),
    .ttl      (ttl),
    .key_a    (rd_key),
    .key_b    (it_key),
    .age      (age),
    .cmp      (cmp)
  );

  always_comb begin
    vidx      = (state == S_MOVE) ? idx[IW-1:0] : p_idx;
    v         = valid[vidx];
    proc      = (state == S_SCAN) && p_vld;
    m_get     = !ev_scan && (it_kind == tce_pkg::KIND_GET);
    m_put     = !ev_scan && (it_kind == tce_pkg::KIND_PUT);
    m_purge   = !ev_scan && (it_kind == tce_pkg::KIND_PURGE);
    get_take  = proc && m_get && v && cmp.key_eq && !found;
    hit_take  = get_take && !cmp.expired;
    // a get drops an expired match; a put drops the old copy of its key and every expired entry
    kill      = proc && v && ((m_get && cmp.key_eq && !found && cmp.expired) ||
                              (m_put && (cmp.key_eq || cmp.expired)) ||
                              (m_purge && cmp.expired));
    // the new entry goes to the lowest slot that is free or holds its key, before expired entries are purged
    fill_take = proc && m_put && !fill_found && (!v || cmp.key_eq);
    best_take = proc && ev_scan && v && (!best_found || cmp.older);
    scan_end  = proc && (p_idx == LAST);
    total     = ent_cnt + CW'(stg_valid);
    limit     = (LW'(max_ent) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_ent);
    over      = (LW'(total) > limit);
    out_load  = (state == S_FIN) && (!out_valid || !out_stall);
    we        = ((state == S_INS) && (ttl != '0) && fill_found) ||
                ((state == S_MOVE) && !v);
    waddr     = (state == S_INS) ? fill_idx : idx[IW-1:0];
    wdata     = {it_key, it_tag, it_err, time_now};
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      p_vld      <= 1'b0;
      valid      <= '0;
      ent_cnt    <= '0;
      err_cnt    <= '0;
      stg_valid  <= 1'b0;
      time_now   <= '0;
      ttl        <= tce_pkg::TTL_RESET;
      max_ent    <= tce_pkg::MAX_RESET;
      ev_scan    <= 1'b0;
      found      <= 1'b0;
      fill_found <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == tce_pkg::REG_TTL) begin
          ttl <= cfg_data[tce_pkg::TTL_W-1:0];
        end else if (cfg_index == tce_pkg::REG_MAX) begin
          max_ent <= cfg_data[tce_pkg::LIM_W-1:0];
        end
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            found      <= 1'b0;
            fill_found <= 1'b0;
            ev_scan    <= 1'b0;
            idx        <= '0;
            p_vld      <= 1'b0;
            case (kind)
              tce_pkg::KIND_TICK: begin
                time_now <= time_now + 1'b1;
                state    <= S_FIN;
              end
              tce_pkg::KIND_GET, tce_pkg::KIND_PUT, tce_pkg::KIND_PURGE: begin
                state <= S_SCAN;
              end
              tce_pkg::KIND_CLEAR: begin
                valid   <= '0;
                ent_cnt <= '0;
                err_cnt <= '0;
                state   <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx != SCAN_N) begin
            p_vld <= 1'b1;
            idx   <= idx + 1'b1;
          end else begin
            p_vld <= 1'b0;
          end
          if (kill) begin
            valid[p_idx] <= 1'b0;
            ent_cnt      <= ent_cnt - 1'b1;
            err_cnt      <= err_cnt - CW'(rd_err);
          end
          if (get_take) begin
            found <= 1'b1;
          end
          if (fill_take) begin
            fill_found <= 1'b1;
          end
          if (best_take) begin
            best_found <= 1'b1;
          end
          if (scan_end) begin
            if (ev_scan) begin
              state <= S_EVCUT;
            end else if (it_kind == tce_pkg::KIND_PUT) begin
              state <= S_INS;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_INS: begin
          // with a zero ttl the new entry is expired at once
          if (ttl != '0) begin
            if (fill_found) begin
              valid[fill_idx] <= 1'b1;
              ent_cnt         <= ent_cnt + 1'b1;
              err_cnt         <= err_cnt + CW'(it_err);
            end else begin
              stg_valid <= 1'b1;
            end
          end
          state <= S_EVCHK;
        end
        S_EVCUT: begin
          // the staged entry is youngest and last, so it goes only when nothing else is left
          if (best_found) begin
            valid[best_idx] <= 1'b0;
            ent_cnt         <= ent_cnt - 1'b1;
            err_cnt         <= err_cnt - CW'(best_err);
          end else begin
            stg_valid <= 1'b0;
          end
          state <= S_EVCHK;
        end
        S_EVCHK: begin
          if (over) begin
            ev_scan    <= 1'b1;
            best_found <= 1'b0;
            idx        <= '0;
            p_vld      <= 1'b0;
            state      <= S_SCAN;
          end else if (stg_valid) begin
            idx   <= '0;
            state <= S_MOVE;
          end else begin
            state <= S_FIN;
          end
        end
        S_MOVE: begin
          if (!v) begin
            valid[idx[IW-1:0]] <= 1'b1;
            ent_cnt            <= ent_cnt + 1'b1;
            err_cnt            <= err_cnt + CW'(it_err);
            stg_valid          <= 1'b0;
            state              <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      it_kind  <= kind;
      it_key   <= key_hash;
      it_tag   <= TAG_WIDTH'(response_tag);
      it_err   <= error_flag;
      hit_r    <= 1'b0;
      hit_resp <= '0;
      hit_err  <= 1'b0;
    end
    if ((state == S_SCAN) && (idx != SCAN_N)) begin
      p_idx <= idx[IW-1:0];
    end
    if (hit_take) begin
      hit_r    <= 1'b1;
      hit_resp <= rd_tag;
      hit_err  <= rd_err;
    end
    if (fill_take) begin
      fill_idx <= p_idx;
    end
    if (best_take) begin
      best_idx <= p_idx;
      best_age <= age;
      best_err <= rd_err;
    end
    if (out_load) begin
      hit          <= hit_r;
      hit_response <= tce_pkg::RESP_W'(hit_resp);
      hit_is_error <= hit_err;
      entry_count  <= tce_pkg::CNT_W'(ent_cnt);
      error_count  <= tce_pkg::CNT_W'(err_cnt);
    end
  end

endmodule

// ----- sv/tce_store.sv -----
// entry store of the ttl cache: one write port, one read port with registered data
// depends on nothing; the top level packs key, tag, error mark and stamp into one word
module tce_store #(
  parameter int DEPTH = 16,
  parameter int W     = 129,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [IW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tce_age_unit.sv -----
// shared age and compare unit: age of one slot, expiry, key match and age ordering
// depends on tce_pkg
module tce_age_unit (
  input  logic [tce_pkg::STAMP_W-1:0] time_now,
  input  logic [tce_pkg::STAMP_W-1:0] stamp,
  input  logic [tce_pkg::STAMP_W-1:0] best_age,
  input  logic [tce_pkg::TTL_W-1:0]   ttl,
  input  logic [tce_pkg::KEY_W-1:0]   key_a,
  input  logic [tce_pkg::KEY_W-1:0]   key_b,
  output logic [tce_pkg::STAMP_W-1:0] age,
  output tce_pkg::cmp_t               cmp
);

  // age wraps modulo 2^32
  assign age         = time_now - stamp;
  assign cmp.key_eq  = (key_a == key_b);
  assign cmp.expired = (age >= tce_pkg::STAMP_W'(ttl));
  assign cmp.older   = (age > best_age);

endmodule

// ----- sv/tce_checker.sv -----
// port-level checks on the result channel of the ttl cache
// bound to ttl_cache_oldest_evict_unit; depends on nothing else
module tce_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [31:0] hit_response,
  input logic        hit_is_error,
  input logic [4:0]  entry_count,
  input logic [4:0]  error_count
);

  // counts stay within the table and error entries are a subset
  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((DEPTH > 31) ||
                   ((entry_count <= 5'(DEPTH)) && (error_count <= entry_count))))
    else $error("entry or error count out of range");

  // a result without a hit carries no response
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> ((hit_response == 32'd0) && !hit_is_error))
    else $error("miss transaction carries response data");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(hit_response) &&
                                  $stable(hit_is_error) && $stable(entry_count) &&
                                  $stable(error_count)))
    else $error("stalled result transaction changed");

  // no result comes straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ttl_cache_oldest_evict_unit tce_checker #(.DEPTH(DEPTH)) u_tce_checker (.*);
